FILE: hw/rtl/rpn_pkg.sv
package rpn_pkg;

   // Token commands as they arrive on the request channel.
   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_UPLUS  = 3'd1,
      CMD_UMINUS = 3'd2,
      CMD_ADD    = 3'd3,
      CMD_SUB    = 3'd4,
      CMD_MUL    = 3'd5,
      CMD_DIV    = 3'd6,
      CMD_NOP    = 3'd7
   } cmd_type;

   // Status reported with each result.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_DIVZERO   = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RD_R,
      S_RD_L,
      S_EXEC,
      S_DIV,
      S_WRITE,
      S_FINISH,
      S_FIN_RD
   } state_type;

   // Source of the word written into the stack memory.
   typedef enum logic [1:0] {
      WR_PUSH = 2'd0,
      WR_RES  = 2'd1,
      WR_QUOT = 2'd2
   } wr_src_type;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned DIV_CNT_W = 5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       tok_load;
      logic       rd_en;
      logic       cap_r;
      logic       cap_l;
      logic       exec;
      logic       div_start;
      logic       div_step;
      logic       wr_en;
      wr_src_type wr_src;
      cmd_type    op;
      logic       out_load;
      logic       out_zero;
      status_type out_status;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic r_zero;
      logic div_done;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: hw/rtl/rpn_ctrl.sv
module rpn_ctrl
   import rpn_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16,
   parameter int unsigned ADDR_W      = 4,
   parameter int unsigned CNT_W       = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic               req_end_of_expression,
   output ctrl_cmd_type       ctrl_cmd,
   output logic [ADDR_W-1:0]  mem_addr,
   input  dp_stat_type        dp_stat
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       err_ff, err_in;
   cmd_type          cmd_ff, cmd_in;
   logic             eoe_ff, eoe_in;

   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W-1:0] cnt_m2;

   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_m2 = count_ff - CNT_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         err_ff   <= ST_OK;
         cmd_ff   <= CMD_NOP;
         eoe_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff   <= err_in;
         cmd_ff   <= cmd_in;
         eoe_ff   <= eoe_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      err_in     = err_ff;
      cmd_in     = cmd_ff;
      eoe_in     = eoe_ff;
      ctrl_cmd   = '0;
      ctrl_cmd.op = cmd_ff;
      mem_addr   = cnt_m1[ADDR_W-1:0];
      req_stall  = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl_cmd.tok_load = 1'b1;
               cmd_in   = cmd_type'(req_command);
               eoe_in   = req_end_of_expression;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_FINISH;
            if (err_ff == ST_OK) begin
               unique case (cmd_ff) inside
                  CMD_PUSH: begin
                     if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        ctrl_cmd.wr_en  = 1'b1;
                        ctrl_cmd.wr_src = WR_PUSH;
                        mem_addr        = count_ff[ADDR_W-1:0];
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_UPLUS, CMD_UMINUS: begin
                     if (count_ff == '0) begin
                        err_in = ST_UNDERFLOW;
                     end else if (cmd_ff == CMD_UMINUS) begin
                        ctrl_cmd.rd_en = 1'b1;
                        state_in       = S_RD_R;
                     end
                  end
                  CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                     if (count_ff < CNT_W'(2)) begin
                        err_in = ST_UNDERFLOW;
                     end else begin
                        ctrl_cmd.rd_en = 1'b1;
                        state_in       = S_RD_R;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_RD_R: begin
            ctrl_cmd.cap_r = 1'b1;
            if (cmd_ff == CMD_UMINUS) begin
               state_in = S_EXEC;
            end else begin
               ctrl_cmd.rd_en = 1'b1;
               mem_addr       = cnt_m2[ADDR_W-1:0];
               state_in       = S_RD_L;
            end
         end

         S_RD_L: begin
            ctrl_cmd.cap_l = 1'b1;
            state_in       = S_EXEC;
         end

         S_EXEC: begin
            if (cmd_ff == CMD_DIV) begin
               if (dp_stat.r_zero) begin
                  err_in   = ST_DIVZERO;
                  state_in = S_FINISH;
               end else begin
                  ctrl_cmd.div_start = 1'b1;
                  state_in           = S_DIV;
               end
            end else begin
               ctrl_cmd.exec = 1'b1;
               state_in      = S_WRITE;
            end
         end

         S_DIV: begin
            ctrl_cmd.div_step = 1'b1;
            if (dp_stat.div_done) begin
               state_in = S_WRITE;
            end
         end

         S_WRITE: begin
            ctrl_cmd.wr_en  = 1'b1;
            ctrl_cmd.wr_src = (cmd_ff == CMD_DIV) ? WR_QUOT : WR_RES;
            state_in        = S_FINISH;
            if (cmd_ff != CMD_UMINUS) begin
               mem_addr = cnt_m2[ADDR_W-1:0];
               count_in = cnt_m1;
            end
         end

         S_FINISH: begin
            if (!eoe_ff) begin
               state_in = S_IDLE;
            end else if (err_ff != ST_OK || count_ff == '0) begin
               if (dp_stat.out_free) begin
                  ctrl_cmd.out_load   = 1'b1;
                  ctrl_cmd.out_zero   = 1'b1;
                  ctrl_cmd.out_status = (err_ff == ST_OK) ? ST_UNDERFLOW : err_ff;
                  count_in            = '0;
                  err_in              = ST_OK;
                  state_in            = S_IDLE;
               end
            end else begin
               ctrl_cmd.rd_en = 1'b1;
               state_in       = S_FIN_RD;
            end
         end

         S_FIN_RD: begin
            if (dp_stat.out_free) begin
               ctrl_cmd.out_load   = 1'b1;
               ctrl_cmd.out_status = ST_OK;
               count_in            = '0;
               err_in              = ST_OK;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count exceeds depth");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_load |-> dp_stat.out_free)
      else $error("result loaded into a full output register");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_load |=> (count_ff == '0 && err_ff == ST_OK))
      else $error("stack not cleared after a result");

   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && !ctrl_cmd.out_load) |=> ($stable(count_ff) && $stable(err_ff)))
      else $error("state changed while an error is pending");
`endif

endmodule

FILE: hw/rtl/rpn_dpath.sv
module rpn_dpath
   import rpn_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16,
   parameter int unsigned ADDR_W      = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [DATA_W-1:0] req_operand_value,
   input  ctrl_cmd_type             ctrl_cmd,
   input  logic [ADDR_W-1:0]        mem_addr,
   output dp_stat_type              dp_stat,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic [1:0]               rsp_status
);

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] r_ff;
   logic [DATA_W-1:0] l_ff;
   logic [DATA_W-1:0] res_ff, res_in;

   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    den_ff;
   logic                 neg_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DATA_W:0]      rem_sh;
   logic [DATA_W:0]      diff;

   logic [DATA_W-1:0] wr_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] result_ff;
   status_type        status_ff;

   // Stack memory: one shared address, registered read data.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.wr_en) begin
         stack_mem[mem_addr] <= wr_data;
      end
      if (ctrl_cmd.rd_en) begin
         rd_data_ff <= stack_mem[mem_addr];
      end
   end

   always_comb begin
      case (ctrl_cmd.op)
         CMD_UMINUS: res_in = DATA_W'(0) - r_ff;
         CMD_ADD:    res_in = l_ff + r_ff;
         CMD_SUB:    res_in = l_ff - r_ff;
         CMD_MUL:    res_in = l_ff * r_ff;
         default:    res_in = r_ff;
      endcase
   end

   // Restoring divider on magnitudes, one quotient bit per cycle.
   assign rem_sh = {rem_ff, quo_ff[DATA_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_comb begin
      if (!diff[DATA_W]) begin
         rem_in = diff[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], 1'b1};
      end else begin
         rem_in = rem_sh[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.tok_load) begin
         val_ff <= req_operand_value;
      end
      if (ctrl_cmd.cap_r) begin
         r_ff <= rd_data_ff;
      end
      if (ctrl_cmd.cap_l) begin
         l_ff <= rd_data_ff;
      end
      if (ctrl_cmd.exec) begin
         res_ff <= res_in;
      end
      if (ctrl_cmd.div_start) begin
         neg_ff     <= l_ff[DATA_W-1] ^ r_ff[DATA_W-1];
         quo_ff     <= l_ff[DATA_W-1] ? DATA_W'(0) - l_ff : l_ff;
         den_ff     <= r_ff[DATA_W-1] ? DATA_W'(0) - r_ff : r_ff;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (ctrl_cmd.div_step) begin
         quo_ff     <= quo_in;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_comb begin
      case (ctrl_cmd.wr_src)
         WR_PUSH: wr_data = val_ff;
         WR_RES:  wr_data = res_ff;
         WR_QUOT: wr_data = neg_ff ? DATA_W'(0) - quo_ff : quo_ff;
         default: wr_data = res_ff;
      endcase
   end

   // Output register.
   assign dp_stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign dp_stat.r_zero   = (r_ff == '0);
   assign dp_stat.div_done = (div_cnt_ff == '1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.out_load) begin
         result_ff <= ctrl_cmd.out_zero ? '0 : rd_data_ff;
         status_ff <= ctrl_cmd.out_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = result_ff;
   assign rsp_status       = status_ff;

endmodule

FILE: hw/rtl/rpn_stack_evaluator_top.sv
// Postfix evaluator: divide is the slowest token, and the 32-step
// one-bit-per-cycle divider sets the worst case.
// A token marked last on a non-empty stack with no error adds a read of the top
// entry, and the result is loaded into the output register once that is free.
// Reset is synchronous and active high; it clears the controller, the stack count,
// the error and the output valid. The stack memory is not cleared and needs no pass.
module rpn_stack_evaluator_top
   import rpn_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_command,
   input  logic signed [DATA_W-1:0] req_operand_value,
   input  logic                     req_end_of_expression,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic [1:0]               rsp_status
);

   // The stack address covers the depth; the count must also hold the depth itself.
   localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

   ctrl_cmd_type      ctrl_cmd;
   dp_stat_type       dp_stat;
   logic [ADDR_W-1:0] mem_addr;

   // The controller sequences each token: decode, operand reads, execute or
   // divide, write back and, at the end of an expression, the result transfer.
   rpn_ctrl #(
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_W      (ADDR_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_end_of_expression (req_end_of_expression),
      .ctrl_cmd              (ctrl_cmd),
      .mem_addr              (mem_addr),
      .dp_stat               (dp_stat)
   );

   // The datapath holds the stack memory, operand registers, the arithmetic
   // unit, the serial divider and the output register, which lets a finished
   // result wait for its transfer while the next token is being taken.
   rpn_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_operand_value (req_operand_value),
      .ctrl_cmd          (ctrl_cmd),
      .mem_addr          (mem_addr),
      .dp_stat           (dp_stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status)
   );

endmodule

FILE: bench/rpn_result_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the evaluator, keeps its own copy of the operand
// stack and predicts every result; each result transfer is compared with the
// oldest prediction still waiting.
module rpn_result_checker
   import rpn_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [2:0]               req_command,
   input  logic signed [DATA_W-1:0] req_operand_value,
   input  logic                     req_end_of_expression,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_result_value,
   input  logic [1:0]               rsp_status,
   output int                       fail_count,
   output int                       pending_count,
   output int                       clean_count,
   output int                       flagged_count
);

   typedef struct packed {
      logic [DATA_W-1:0] value;
      status_type        status;
   } result_type;

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   int unsigned       depth;
   status_type        sticky_err;
   result_type        predicted_q[$];

   function automatic logic [DATA_W-1:0] div_toward_zero(input logic [DATA_W-1:0] num,
                                                         input logic [DATA_W-1:0] den);
      logic [DATA_W-1:0] mag_n, mag_d, quo;
      mag_n = num[DATA_W-1] ? -num : num;
      mag_d = den[DATA_W-1] ? -den : den;
      quo   = mag_n / mag_d;
      return (num[DATA_W-1] != den[DATA_W-1]) ? -quo : quo;
   endfunction

   task automatic eval_token(input cmd_type cmd, input logic [DATA_W-1:0] val);
      logic [DATA_W-1:0] lhs, rhs, res;
      // The first error freezes the stack until the expression ends.
      if (sticky_err != ST_OK) return;
      case (cmd)
         CMD_PUSH: begin
            if (depth >= STACK_DEPTH) begin
               sticky_err = ST_OVERFLOW;
            end else begin
               stack_mem[depth] = val;
               depth++;
            end
         end
         CMD_UPLUS, CMD_UMINUS: begin
            if (depth == 0) begin
               sticky_err = ST_UNDERFLOW;
            end else if (cmd == CMD_UMINUS) begin
               stack_mem[depth-1] = -stack_mem[depth-1];
            end
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
            if (depth < 2) begin
               sticky_err = ST_UNDERFLOW;
               return;
            end
            rhs = stack_mem[depth-1];
            lhs = stack_mem[depth-2];
            if (cmd == CMD_DIV && rhs == '0) begin
               sticky_err = ST_DIVZERO;
               return;
            end
            case (cmd)
               CMD_ADD: res = lhs + rhs;
               CMD_SUB: res = lhs - rhs;
               CMD_MUL: res = lhs * rhs;
               default: res = div_toward_zero(lhs, rhs);
            endcase
            depth--;
            stack_mem[depth-1] = res;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      result_type want;
      int         fails_now;
      fails_now = 0;
      if (reset) begin
         depth      = 0;
         sticky_err = ST_OK;
         predicted_q.delete();
         pending_count <= 0;
         fail_count    <= 0;
         clean_count   <= 0;
         flagged_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            eval_token(cmd_type'(req_command), req_operand_value);
            if (req_end_of_expression) begin
               want.value  = '0;
               want.status = sticky_err;
               if (sticky_err == ST_OK) begin
                  if (depth == 0) want.status = ST_UNDERFLOW;
                  else want.value = stack_mem[depth-1];
               end
               predicted_q.push_back(want);
               depth      = 0;
               sticky_err = ST_OK;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_q.size() == 0) begin
               $display("%0t: unexpected result value %0d status %0d", $time,
                        rsp_result_value, rsp_status);
               fails_now++;
            end else begin
               want = predicted_q.pop_front();
               if (rsp_result_value !== want.value) begin
                  $display("%0t: result_value expected %0d, got %0d", $time,
                           $signed(want.value), rsp_result_value);
                  fails_now++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time,
                           want.status, rsp_status);
                  fails_now++;
               end
               if (want.status == ST_OK) clean_count <= clean_count + 1;
               else flagged_count <= flagged_count + 1;
            end
         end
         fail_count    <= fail_count + fails_now;
         pending_count <= predicted_q.size();
      end
   end

endmodule

FILE: bench/rpn_stack_evaluator_top_tb.sv
`timescale 1ns / 100ps

// Bench for the postfix evaluator. This top only makes stimulus and gives the
// verdict; prediction and comparison live in the checker instantiated below.
module rpn_stack_evaluator_top_tb;
   import rpn_pkg::*;

   localparam int unsigned DEPTH            = 16;
   // Number of random tokens after the directed part.
   localparam int          TOKEN_GOAL       = 1350;
   // From this token count on, neither side idles any more.
   localparam int          CALM_FROM        = 1100;
   // Points in the random part where the receiver holds off for a long time
   // and where the sender drains the block.
   localparam int          HOLD_AT          = 400;
   localparam int          PAUSE_AT         = 700;
   localparam int          LONG_HOLD_CYCLES = 600;
   // A divide token is the slowest, more so when marked last; leave margin.
   localparam int          TAIL_CYCLES      = 60;

   typedef struct {
      cmd_type           cmd;
      logic [DATA_W-1:0] val;
   } token_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [2:0]               req_command = CMD_NOP;
   logic signed [DATA_W-1:0] req_operand_value = '0;
   logic                     req_end_of_expression = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic [1:0]               rsp_status;

   int fail_count, pending_count, clean_count, flagged_count;

   // Shared controls: idle_on enables random gaps on both sides, long_hold
   // asks the receiver for one long stall and is cleared by it when done.
   bit idle_on   = 1'b1;
   bit long_hold = 1'b0;
   int tokens_sent = 0;
   token_type expr_q[$];

   always #4 clock = ~clock;

   rpn_stack_evaluator_top #(.STACK_DEPTH(DEPTH)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_operand_value     (req_operand_value),
      .req_end_of_expression (req_end_of_expression),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_value      (rsp_result_value),
      .rsp_status            (rsp_status)
   );

   rpn_result_checker #(.STACK_DEPTH(DEPTH)) u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_operand_value     (req_operand_value),
      .req_end_of_expression (req_end_of_expression),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_value      (rsp_result_value),
      .rsp_status            (rsp_status),
      .fail_count            (fail_count),
      .pending_count         (pending_count),
      .clean_count           (clean_count),
      .flagged_count         (flagged_count)
   );

   // Operand values lean toward the corners: zero, one, minus one, the two
   // extremes and small numbers, with fully random words for bit coverage.
   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return 32'($urandom_range(0, 200)) - 32'd100;
         default: return 32'($urandom());
      endcase
   endfunction

   function automatic void add_token(input cmd_type cmd, input logic [DATA_W-1:0] val);
      token_type tok;
      tok.cmd = cmd;
      tok.val = val;
      expr_q.push_back(tok);
   endfunction

   // Offers one token and returns once its transfer has happened. Valid stays
   // high across back-to-back transfers and is only lowered for an idle burst.
   task automatic send_token(input cmd_type cmd, input logic [DATA_W-1:0] val,
                             input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_command           <= cmd;
      req_operand_value     <= val;
      req_end_of_expression <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokens_sent++;
   endtask

   // Sends the queued expression, marking its final token as the last one.
   task automatic send_expression();
      foreach (expr_q[i]) send_token(expr_q[i].cmd, expr_q[i].val, i == expr_q.size() - 1);
      expr_q.delete();
   endtask

   // The pending count is a registered value in the checker, so the task waits
   // for its update before trusting it.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Most random expressions are well formed, so that deep stacks and every
   // operator on live data are reached; the rest are overflow runs and
   // arbitrary token strings, which exercise underflow, the unused command and
   // errors stacking on earlier errors.
   task automatic build_random_expression();
      int kind, pushes, held, n;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         n = $urandom_range(DEPTH + 1, DEPTH + 3);
         repeat (n) add_token(CMD_PUSH, pick_operand());
         if ($urandom_range(0, 1) == 0) add_token(CMD_ADD, pick_operand());
      end else if (kind <= 3) begin
         n = $urandom_range(1, 8);
         repeat (n) add_token(cmd_type'($urandom_range(CMD_PUSH, CMD_NOP)), pick_operand());
      end else begin
         // A few expressions climb toward the full depth; most stay shallow.
         pushes = ($urandom_range(0, 5) == 0) ? $urandom_range(6, DEPTH) : $urandom_range(1, 5);
         held   = 0;
         while (pushes > 0 || held > 1) begin
            if ($urandom_range(0, 19) == 0) add_token(CMD_NOP, pick_operand());
            if (pushes > 0 && (held < 2 || $urandom_range(0, 2) == 0)) begin
               add_token(CMD_PUSH, pick_operand());
               held++;
               pushes--;
            end else if ($urandom_range(0, 5) == 0) begin
               add_token(cmd_type'($urandom_range(CMD_UPLUS, CMD_UMINUS)), pick_operand());
            end else begin
               add_token(cmd_type'($urandom_range(CMD_ADD, CMD_DIV)), pick_operand());
               held--;
            end
         end
         if ($urandom_range(0, 5) == 0) add_token(CMD_UMINUS, pick_operand());
      end
   endtask

   // Receiver: random stall bursts while idling is enabled, and one long
   // hold on request, counted here, during which the block has to back up
   // into its input channel.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sender and verdict.
   initial begin
      bit hold_done, pause_done;
      int goal;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A lone push returns the largest value.
      add_token(CMD_PUSH, 32'h7FFF_FFFF);
      send_expression();
      // The most negative value over minus one wraps without an error.
      add_token(CMD_PUSH, 32'h8000_0000);
      add_token(CMD_PUSH, 32'hFFFF_FFFF);
      add_token(CMD_DIV, 32'd0);
      send_expression();
      // Seven over minus two truncates toward zero.
      add_token(CMD_PUSH, 32'd7);
      add_token(CMD_PUSH, -32'd2);
      add_token(CMD_DIV, 32'd0);
      send_expression();
      // Divide by zero is reported even though the add after it would underflow.
      add_token(CMD_PUSH, 32'd5);
      add_token(CMD_PUSH, 32'd0);
      add_token(CMD_DIV, 32'hFFFF_FFFF);
      add_token(CMD_ADD, 32'd0);
      send_expression();
      // Binary and unary operators on an empty stack underflow.
      add_token(CMD_ADD, 32'h8000_0000);
      send_expression();
      add_token(CMD_UMINUS, 32'd0);
      send_expression();
      // Negate, unary plus, and the end mark honored on the unused command.
      add_token(CMD_PUSH, 32'd3);
      add_token(CMD_UMINUS, 32'd0);
      add_token(CMD_UPLUS, 32'd0);
      add_token(CMD_NOP, 32'h7FFF_FFFF);
      send_expression();
      // Wrapping add and multiply, then subtract.
      add_token(CMD_PUSH, 32'h7FFF_FFFF);
      add_token(CMD_PUSH, 32'd1);
      add_token(CMD_ADD, 32'd0);
      add_token(CMD_PUSH, 32'd3);
      add_token(CMD_MUL, 32'd0);
      add_token(CMD_PUSH, 32'd10);
      add_token(CMD_SUB, 32'd0);
      send_expression();
      // An end mark on an empty stack reports underflow.
      add_token(CMD_NOP, 32'hFFFF_FFFF);
      send_expression();

      // Random part.
      goal = tokens_sent + TOKEN_GOAL;
      while (tokens_sent < goal) begin
         idle_on = (tokens_sent < goal - TOKEN_GOAL + CALM_FROM);
         if (!hold_done && tokens_sent >= goal - TOKEN_GOAL + HOLD_AT) begin
            // The sender keeps offering while the receiver holds off.
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && tokens_sent >= goal - TOKEN_GOAL + PAUSE_AT) begin
            // The sender stops until every predicted result has arrived.
            req_valid <= 1'b0;
            wait_drained();
            pause_done = 1'b1;
         end
         build_random_expression();
         send_expression();
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d tokens: corner cases, well-formed expressions up to depth %0d,",
               tokens_sent, DEPTH);
      $display("overflow runs and random token strings; %0d results clean, %0d with error status.",
               clean_count, flagged_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #(5_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: rpn_stack_evaluator_top.f
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_ctrl.sv
hw/rtl/rpn_dpath.sv
hw/rtl/rpn_stack_evaluator_top.sv
bench/rpn_result_checker.sv
bench/rpn_stack_evaluator_top_tb.sv
